// ----- design/assert_macros.svh -----
// Assertion macros for the box suppression RTL.
// Depends on a clock named clock and a reset named reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define GBS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Check that cons holds in the cycle after ante.
`define GBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ----- design/gbs_pkg.sv -----
// Shared types and constants for the greedy box suppression block.
// No dependencies.
`timescale 1ns / 1ps

package gbs_pkg;

   localparam int MAX_BOXES    = 64;
   localparam int RESULT_LIMIT = 64;
   localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);
   localparam int THR_RESET    = 29491;
   localparam int PADDR_W      = 3;
   localparam int CMP_WAIT     = 4;

   typedef struct packed {
      logic [15:0] box_x;
      logic [15:0] box_y;
      logic [15:0] box_w;
      logic [15:0] box_h;
      logic [15:0] box_score;
      logic        final_box;
   } req_word_type;

   typedef struct packed {
      logic [15:0] kept_x;
      logic [15:0] kept_y;
      logic [15:0] kept_w;
      logic [15:0] kept_h;
      logic [15:0] kept_score;
      logic        final_kept;
   } rsp_word_type;

   // one stored box
   typedef struct packed {
      logic        live;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
      logic [15:0] score;
      logic [31:0] area;
   } entry_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic ins_en;
      logic shift_en;
      logic clear;
      logic apply;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_HEAD,
      ST_CMP,
      ST_EMIT
   } state_type;

endpackage

// ----- design/gbs_cell.sv -----
// One cell of the sorted box chain: holds a box, inserts and shifts, and tests
// overlap against the broadcast head box. Depends on gbs_pkg.
`timescale 1ns / 1ps

module gbs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  gbs_pkg::cell_ctrl_type ctrl,
   input  gbs_pkg::entry_type    new_ent,
   input  gbs_pkg::entry_type    head_ent,
   input  logic [15:0]           thr,
   input  gbs_pkg::entry_type    prev_ent,
   input  logic                  prev_ins,
   input  gbs_pkg::entry_type    next_ent,
   output gbs_pkg::entry_type    ent,
   output logic                  ins_here
);

   gbs_pkg::entry_type ent_ff, ent_in;
   logic [16:0] ow_ff, oh_ff, ow_in, oh_in;
   logic [33:0] over_ff, over2_ff;
   logic [32:0] uni_ff;
   logic        sup_ff;

   logic [15:0] left, top;
   logic [16:0] right, bottom, ae, be;
   logic [49:0] lhs, rhs;

   assign ent      = ent_ff;
   assign ins_here = !ent_ff.live || (ent_ff.score < new_ent.score);

   always_comb begin
      ent_in = ent_ff;
      if (ctrl.clear) begin
         ent_in.live = 1'b0;
      end else if (ctrl.ins_en) begin
         if (ins_here && !prev_ins) begin
            ent_in = new_ent;
         end else if (ins_here) begin
            ent_in = prev_ent;
         end
      end else if (ctrl.shift_en) begin
         ent_in = next_ent;
      end else if (ctrl.apply && sup_ff) begin
         ent_in.live = 1'b0;
      end
   end

   // overlap extents
   always_comb begin
      left   = (head_ent.x > ent_ff.x) ? head_ent.x : ent_ff.x;
      top    = (head_ent.y > ent_ff.y) ? head_ent.y : ent_ff.y;
      ae     = {1'b0, head_ent.x} + {1'b0, head_ent.w};
      be     = {1'b0, ent_ff.x} + {1'b0, ent_ff.w};
      right  = (ae < be) ? ae : be;
      ae     = {1'b0, head_ent.y} + {1'b0, head_ent.h};
      be     = {1'b0, ent_ff.y} + {1'b0, ent_ff.h};
      bottom = (ae < be) ? ae : be;
      ow_in  = (right > {1'b0, left}) ? (right - {1'b0, left}) : 17'd0;
      oh_in  = (bottom > {1'b0, top}) ? (bottom - {1'b0, top}) : 17'd0;
      lhs    = {over2_ff, 16'd0};
      rhs    = {1'b0, 49'(thr) * 49'(uni_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.live <= 1'b0;
      end else begin
         ent_ff.live <= ent_in.live;
      end
      ent_ff.x     <= ent_in.x;
      ent_ff.y     <= ent_in.y;
      ent_ff.w     <= ent_in.w;
      ent_ff.h     <= ent_in.h;
      ent_ff.score <= ent_in.score;
      ent_ff.area  <= ent_in.area;
      ow_ff    <= ow_in;
      oh_ff    <= oh_in;
      over_ff  <= ow_ff * oh_ff;
      over2_ff <= over_ff;
      uni_ff   <= {1'b0, ent_ff.area} + {1'b0, head_ent.area} - over_ff[32:0];
      sup_ff   <= lhs > rhs;
   end

endmodule

// ----- design/greedy_box_suppression.sv -----
// Top level of the greedy box suppression block: the cell chain, the
// sequencer and the threshold register. Depends on gbs_pkg and gbs_cell.
//
//   channel | ports                        | word
//   --------+------------------------------+-------------------------------
//   req     | req_valid, req_ready         | req_data (gbs_pkg::req_word_type)
//   rsp     | rsp_valid, rsp_ready         | rsp_data (gbs_pkg::rsp_word_type)
//   csr     | psel penable pwrite paddr .. | iou_threshold at address 0
//
// Cycles: a box is taken every cycle while loading; the sorted insert into the
// cell chain finishes in that cycle. After the final box, each suppressed chain
// position is moved up in turn; each survivor gets a head check, an overlap test
// (four-stage cell pipeline, then one apply) and then waits until its word is
// taken.
// Reset: clears the chain's live bits and the sequencer, and loads the threshold
// with its default.
// Stalls: a held rsp word freezes the chain; req_ready stays low until the
// frame's last survivor is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module greedy_box_suppression (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  gbs_pkg::req_word_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output gbs_pkg::rsp_word_type             rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gbs_pkg::PADDR_W-1:0]       paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   localparam int N = gbs_pkg::MAX_BOXES;

   gbs_pkg::state_type    state_ff, state_in;
   logic [gbs_pkg::CNT_W-1:0] sent_ff, sent_in;
   logic [2:0]            wait_ff, wait_in;
   logic [15:0]           thr_ff;

   gbs_pkg::entry_type    ents [N];
   gbs_pkg::entry_type    new_ent, dead_ent;
   logic [N-1:0]          ins_v;
   logic [N-1:0]          live_v;
   logic                  rest_live;
   gbs_pkg::cell_ctrl_type ctrl, ctrl0;
   logic                  take_req, take_rsp, is_last;
   logic                  thr_sel;

   // configuration register; the word index is the address above the byte bits
   assign pready  = 1'b1;
   assign thr_sel = (paddr[gbs_pkg::PADDR_W-1:2] == '0);
   assign prdata  = thr_sel ? {16'd0, thr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 16'(gbs_pkg::THR_RESET);
      end else if (psel && penable && pwrite && thr_sel) begin
         thr_ff <= pwdata[15:0];
      end
   end

   // broadcast word for insertion; area computed on the way in
   always_comb begin
      new_ent.live  = 1'b1;
      new_ent.x     = req_data.box_x;
      new_ent.y     = req_data.box_y;
      new_ent.w     = req_data.box_w;
      new_ent.h     = req_data.box_h;
      new_ent.score = req_data.box_score;
      new_ent.area  = req_data.box_w * req_data.box_h;
      dead_ent      = new_ent;
      dead_ent.live = 1'b0;
   end

   // cell chain: insert shifts down, drain shifts up
   for (genvar i = 0; i < N; i++) begin : g_cell
      gbs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     ((i == 0) ? ctrl0 : ctrl),
         .new_ent  (new_ent),
         .head_ent (ents[0]),
         .thr      (thr_ff),
         .prev_ent ((i == 0) ? dead_ent : ents[(i == 0) ? 0 : i - 1]),
         .prev_ins ((i == 0) ? 1'b0 : ins_v[(i == 0) ? 0 : i - 1]),
         .next_ent ((i == N - 1) ? dead_ent : ents[(i == N - 1) ? i : i + 1]),
         .ent      (ents[i]),
         .ins_here (ins_v[i])
      );
      assign live_v[i] = ents[i].live;
   end

   assign rest_live = |live_v[N-1:1];
   assign take_req  = req_valid && req_ready;
   assign take_rsp  = rsp_valid && rsp_ready;
   assign is_last   = !rest_live ||
                      (sent_ff == (gbs_pkg::CNT_W)'(gbs_pkg::RESULT_LIMIT - 1));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sent_in       = sent_ff;
      wait_in       = wait_ff;
      ctrl          = '0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      case (state_ff)
         gbs_pkg::ST_LOAD: begin
            req_ready   = 1'b1;
            ctrl.ins_en = take_req;
            sent_in     = '0;
            if (take_req && req_data.final_box) begin
               state_in = gbs_pkg::ST_HEAD;
            end
         end
         gbs_pkg::ST_HEAD: begin
            wait_in = '0;
            if (live_v[0]) begin
               state_in = gbs_pkg::ST_CMP;
            end else if (rest_live) begin
               ctrl.shift_en = 1'b1;
            end else begin
               state_in = gbs_pkg::ST_LOAD;
            end
         end
         gbs_pkg::ST_CMP: begin
            wait_in = wait_ff + 3'd1;
            if (wait_ff == 3'(gbs_pkg::CMP_WAIT)) begin
               ctrl.apply = 1'b1;
               state_in   = gbs_pkg::ST_EMIT;
            end
         end
         gbs_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (take_rsp) begin
               sent_in = sent_ff + 1'b1;
               if (is_last) begin
                  ctrl.clear = 1'b1;
                  state_in   = gbs_pkg::ST_LOAD;
               end else begin
                  ctrl.shift_en = 1'b1;
                  state_in      = gbs_pkg::ST_HEAD;
               end
            end
         end
         default: begin
            state_in = gbs_pkg::ST_LOAD;
         end
      endcase
      ctrl0       = ctrl;
      ctrl0.apply = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbs_pkg::ST_LOAD;
         sent_ff  <= '0;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sent_ff  <= sent_in;
         wait_ff  <= wait_in;
      end
   end

   // result word straight from the head cell
   always_comb begin
      rsp_data.kept_x     = ents[0].x;
      rsp_data.kept_y     = ents[0].y;
      rsp_data.kept_w     = ents[0].w;
      rsp_data.kept_h     = ents[0].h;
      rsp_data.kept_score = ents[0].score;
      rsp_data.final_kept = is_last;
   end

   `GBS_ASSERT_SAME(a_no_overlap_phase, rsp_valid, !req_ready)
   `GBS_ASSERT_SAME(a_head_alive, rsp_valid, live_v[0])
   `GBS_ASSERT_NEXT(a_last_frees, take_rsp && rsp_data.final_kept, req_ready && !live_v[0])
   `GBS_ASSERT_NEXT(a_plain_box_stays, take_req && !req_data.final_box, req_ready)

endmodule
